@@ src/utf8_to_utf16_transcoder_defines.svh @@
// Assertion macros shared by the transcoder's checker.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define U8TO16_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("transcoder port check failed");

// Next-cycle implication, disabled during reset.
`define U8TO16_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("transcoder port check failed");

`endif

@@ src/u8to16_pkg.sv @@
// Types, constants and the lead-byte classifier of the UTF-8 to UTF-16 transcoder.
// No dependencies; every other file of the block but the queue and the macro header imports it.
package u8to16_pkg;

	// Class of a byte, taken from its top five bits.
	typedef enum logic [2:0] {
		CLS_CONT  = 3'd0,
		CLS_ASCII = 3'd1,
		CLS_LEAD2 = 3'd2,
		CLS_LEAD3 = 3'd3,
		CLS_LEAD4 = 3'd4,
		CLS_BAD   = 3'd5
	} byte_cls_t;

	localparam logic [15:0] REPL_RESET = 16'd63;
	localparam logic [15:0] SURR_HIGH  = 16'hD800;
	localparam logic [15:0] SURR_LOW   = 16'hDC00;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	// One byte of the input string.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_end;
	} utf8_item_t;

	// One UTF-16 code unit with its markers.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        run_last;
		logic        string_last;
	} utf16_item_t;

	// Work for the back end: some replacement units, then up to two literal units.
	typedef struct packed {
		logic [2:0]  rep_cnt;
		logic [1:0]  lit_cnt;
		logic [15:0] lit0;
		logic [15:0] lit1;
		logic        string_end;
	} job_t;

	function automatic byte_cls_t lead_class(input logic [4:0] top);
		byte_cls_t c;
		case (top) inside
			[5'd0:5'd15]:  c = CLS_ASCII;
			[5'd16:5'd23]: c = CLS_CONT;
			[5'd24:5'd27]: c = CLS_LEAD2;
			[5'd28:5'd29]: c = CLS_LEAD3;
			5'd30:         c = CLS_LEAD4;
			default:       c = CLS_BAD;
		endcase
		return c;
	endfunction

endpackage

@@ src/u8to16_fifo.sv @@
// Small register queue used between the front end, back end and result port.
// No package dependency.
module u8to16_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage; entries need no reset since the count guards every read.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ src/u8to16_front.sv @@
// Front end: classifies each byte, tracks the open sequence and builds at most one job per byte.
// Depends on u8to16_pkg.
module u8to16_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  u8to16_pkg::utf8_item_t  utf8,
	output logic                    job_push,
	output u8to16_pkg::job_t        job
);
	import u8to16_pkg::*;

	logic [7:0]  pbyte_q [3];
	logic [1:0]  pcnt_q;
	logic [1:0]  need_q;

	logic [7:0]  b;
	logic        str_end;
	byte_cls_t   cls;
	logic        fresh;
	logic [2:0]  reps;
	logic [1:0]  lits;
	logic [15:0] lit0;
	logic [15:0] lit1;
	logic [20:0] cp;
	logic [20:0] v;
	logic [1:0]  pcnt_d;
	logic [1:0]  need_d;
	logic        pb_we;
	logic [1:0]  pb_idx;

	assign b       = utf8.data_byte;
	assign str_end = utf8.string_end;
	assign cls     = lead_class(b[7:3]);

	// Code point of a sequence that this continuation completes.
	always_comb begin
		case (need_q)
			2'd1:    cp = {10'd0, pbyte_q[0][4:0], b[5:0]};
			2'd2:    cp = {5'd0, pbyte_q[0][3:0], pbyte_q[1][5:0], b[5:0]};
			2'd3:    cp = {pbyte_q[0][2:0], pbyte_q[1][5:0], pbyte_q[2][5:0], b[5:0]};
			default: cp = '0;
		endcase
		v = cp - SUPP_BASE;
	end

	// Decision for the byte on the input.
	always_comb begin
		fresh  = 1'b1;
		reps   = '0;
		lits   = '0;
		lit0   = '0;
		lit1   = '0;
		pcnt_d = pcnt_q;
		need_d = need_q;
		pb_we  = 1'b0;
		pb_idx = pcnt_q;

		if (pcnt_q != 2'd0) begin
			if (cls == CLS_CONT) begin
				fresh = 1'b0;
				if (pcnt_q == need_q) begin
					pcnt_d = '0;
					need_d = '0;
					if (cp[20:16] != 5'd0) begin
						lits = 2'd2;
						lit0 = SURR_HIGH + {5'd0, v[20:10]};
						lit1 = SURR_LOW + {6'd0, v[9:0]};
					end else begin
						lits = 2'd1;
						lit0 = cp[15:0];
					end
				end else if (str_end || pcnt_q == 2'd3) begin
					// Cut-off sequence: every held byte plus this one is undecodable.
					reps   = {1'b0, pcnt_q} + 3'd1;
					pcnt_d = '0;
					need_d = '0;
				end else begin
					pb_we  = 1'b1;
					pcnt_d = pcnt_q + 2'd1;
				end
			end else begin
				// Broken sequence: flush held bytes, then treat this byte afresh.
				reps   = {1'b0, pcnt_q};
				pcnt_d = '0;
				need_d = '0;
			end
		end

		if (fresh) begin
			case (cls)
				CLS_ASCII: begin
					lits = 2'd1;
					lit0 = {8'd0, b};
				end
				CLS_CONT, CLS_BAD: begin
					reps = reps + 3'd1;
				end
				default: begin
					if (str_end) begin
						reps = reps + 3'd1;
					end else begin
						pb_we  = 1'b1;
						pb_idx = 2'd0;
						pcnt_d = 2'd1;
						need_d = (cls == CLS_LEAD2) ? 2'd1 : (cls == CLS_LEAD3) ? 2'd2 : 2'd3;
					end
				end
			endcase
		end
	end

	assign job.rep_cnt    = reps;
	assign job.lit_cnt    = lits;
	assign job.lit0       = lit0;
	assign job.lit1       = lit1;
	assign job.string_end = str_end;
	assign job_push       = take && (reps != 3'd0 || lits != 2'd0);

	// Held bytes of the open sequence.
	always_ff @(posedge clk) begin
		if (take && pb_we) begin
			pbyte_q[pb_idx] <= b;
		end
	end

	// Sequence bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			need_q <= '0;
		end else if (take) begin
			pcnt_q <= pcnt_d;
			need_q <= need_d;
		end
	end

endmodule

@@ src/u8to16_back.sv @@
// Back end: expands the oldest job into code units, one unit per cycle while a job waits and the result queue has room.
// Depends on u8to16_pkg.
module u8to16_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  u8to16_pkg::job_t        job,
	input  logic                    job_empty,
	output logic                    job_pop,
	input  logic [15:0]             repl_unit,
	input  logic                    out_full,
	output logic                    out_push,
	output u8to16_pkg::utf16_item_t out_item
);
	import u8to16_pkg::*;

	logic [2:0] k_q;
	logic [2:0] total;
	logic       last;
	logic       emit;

	assign total = job.rep_cnt + {1'b0, job.lit_cnt};
	assign last  = (k_q == total - 3'd1);
	assign emit  = !job_empty && !out_full;

	// Replacement units come first, then the literal units.
	always_comb begin
		if (k_q < job.rep_cnt) begin
			out_item.code_unit = repl_unit;
		end else if (k_q == job.rep_cnt) begin
			out_item.code_unit = job.lit0;
		end else begin
			out_item.code_unit = job.lit1;
		end
		out_item.run_last    = last;
		out_item.string_last = last && job.string_end;
	end

	assign out_push = emit;
	assign job_pop  = emit && last;

	// Position within the current job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (emit) begin
			k_q <= last ? '0 : k_q + 3'd1;
		end
	end

endmodule

@@ src/utf8_to_utf16_transcoder.sv @@
// UTF-8 to UTF-16 transcoder: one byte in per cycle, code units out through a small queue.
// A byte is accepted on push && !full; in steady state with ASCII or other single-unit
// results the block sustains one byte per cycle, and the first unit of a byte reaches the
// result port through the job queue and then the result queue. The back end emits one
// code unit per cycle while the result queue has room, so a byte that yields n units
// (two for a surrogate pair, up to four for an error flush) holds the back end until all
// n are out; a JOBQ_DEPTH-entry job queue between front and back absorbs such bursts before
// full rises. Bytes that only open or extend a sequence produce no units. The replacement
// unit resets to '?' and is written over the cfg channel, which is always ready.
// Depends on u8to16_pkg, u8to16_fifo, u8to16_front and u8to16_back.
module utf8_to_utf16_transcoder #(
	parameter int JOBQ_DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  u8to16_pkg::utf8_item_t  utf8,
	output logic                    empty,
	input  logic                    pop,
	output u8to16_pkg::utf16_item_t utf16,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [15:0]             cfg_data
);
	import u8to16_pkg::*;

	localparam int JW = $bits(job_t);
	localparam int UW = $bits(utf16_item_t);

	logic [15:0]   repl_q;
	logic          take;
	logic          job_push;
	job_t          job_in;
	job_t          job_head;
	logic [JW-1:0] job_rdata;
	logic          job_full;
	logic          job_empty;
	logic          job_pop;
	logic          out_full;
	logic          out_push;
	utf16_item_t   out_item;
	logic [UW-1:0] out_rdata;

	assign cfg_ready = 1'b1;
	assign full      = job_full;
	assign take      = push && !job_full;

	// Replacement unit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repl_q <= cfg_data;
		end
	end

	u8to16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.utf8     (utf8),
		.job_push (job_push),
		.job      (job_in)
	);

	u8to16_fifo #(
		.WIDTH (JW),
		.DEPTH (JOBQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (JW'(job_in)),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty)
	);

	assign job_head = job_t'(job_rdata);

	u8to16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_head),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.repl_unit (repl_q),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	u8to16_fifo #(
		.WIDTH (UW),
		.DEPTH (2)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (UW'(out_item)),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign utf16 = utf16_item_t'(out_rdata);

endmodule

@@ src/u8to16_checker.sv @@
// Port-level checker for the transcoder, bound to the top level.
// Depends on u8to16_pkg and utf8_to_utf16_transcoder_defines.svh.
`include "utf8_to_utf16_transcoder_defines.svh"

module u8to16_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    push,
	input logic                    full,
	input logic                    empty,
	input logic                    pop,
	input u8to16_pkg::utf16_item_t utf16
);
	import u8to16_pkg::*;

	// The end of a string always closes the run of its byte.
	`U8TO16_ASSERT_NOW(a_string_last_ends_run, !empty && utf16.string_last, utf16.run_last)

	// A queued job is expanded at once, so a full job queue never meets an empty result port.
	`U8TO16_ASSERT_NOW(a_full_not_empty, full, !empty)

	// The back end keeps feeding results while the input side is held off.
	`U8TO16_ASSERT_NEXT(a_full_keeps_results, full && push, !empty)

	// A waiting result holds until taken.
	`U8TO16_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(utf16))

endmodule

bind utf8_to_utf16_transcoder u8to16_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.utf16  (utf16)
);

@@ tb/sv/tb_utf8_to_utf16_transcoder.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the UTF-8 to UTF-16 transcoder: directed and random byte strings
// go in, and every code unit that comes out is checked against a predictor in a scoreboard.
// Depends on u8to16_pkg and utf8_to_utf16_transcoder.
module tb_utf8_to_utf16_transcoder;
	import u8to16_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES = 75;

	// Predicts the code units of each accepted byte and checks them in order.
	class utf16_scoreboard;
		logic [7:0] held [3];
		int unsigned held_cnt;
		int unsigned need_cnt;
		logic [15:0] repl;
		utf16_item_t expected_units [$];
		int unsigned mismatches;

		function new();
			held_cnt = 0;
			need_cnt = 0;
			repl = REPL_RESET;
			mismatches = 0;
		endfunction

		function void set_repl(input logic [15:0] v);
			repl = v;
		endfunction

		function int outstanding();
			return expected_units.size();
		endfunction

		// Works out the units that one accepted byte causes and queues them.
		function void note_byte(input utf8_item_t it);
			logic [7:0] b;
			byte_cls_t cls;
			logic [15:0] units [$];
			logic [31:0] cp;
			logic [31:0] v;
			bit fresh;
			utf16_item_t unit_item;

			b = it.data_byte;
			fresh = 1'b1;
			if (b < 8'h80)
				cls = CLS_ASCII;
			else if (b < 8'hC0)
				cls = CLS_CONT;
			else if (b < 8'hE0)
				cls = CLS_LEAD2;
			else if (b < 8'hF0)
				cls = CLS_LEAD3;
			else if (b < 8'hF8)
				cls = CLS_LEAD4;
			else
				cls = CLS_BAD;

			// A sequence is open: extend it, complete it or give it up.
			if (held_cnt > 0) begin
				if (cls == CLS_CONT) begin
					fresh = 1'b0;
					if (held_cnt == need_cnt) begin
						case (need_cnt)
							1: cp = {24'd0, held[0] & 8'h1F};
							2: cp = {24'd0, held[0] & 8'h0F};
							default: cp = {24'd0, held[0] & 8'h07};
						endcase
						for (int i = 1; i < held_cnt; i++)
							cp = (cp << 6) | {26'd0, held[i][5:0]};
						cp = (cp << 6) | {26'd0, b[5:0]};
						held_cnt = 0;
						need_cnt = 0;
						if (cp < SUPP_BASE) begin
							units.push_back(cp[15:0]);
						end else begin
							v = cp - SUPP_BASE;
							units.push_back(SURR_HIGH + 16'(v >> 10));
							units.push_back(SURR_LOW + 16'(v & 32'h3FF));
						end
					end else if (it.string_end || held_cnt >= 3) begin
						repeat (held_cnt) units.push_back(repl);
						held_cnt = 0;
						need_cnt = 0;
						units.push_back(repl);
					end else begin
						held[held_cnt] = b;
						held_cnt++;
					end
				end else begin
					repeat (held_cnt) units.push_back(repl);
					held_cnt = 0;
					need_cnt = 0;
				end
			end

			// The byte starts afresh: pass it, reject it or open a sequence.
			if (fresh) begin
				if (cls == CLS_ASCII) begin
					units.push_back({8'h00, b});
				end else if (cls == CLS_CONT || cls == CLS_BAD || it.string_end) begin
					units.push_back(repl);
				end else begin
					held[0] = b;
					held_cnt = 1;
					case (cls)
						CLS_LEAD2: need_cnt = 1;
						CLS_LEAD3: need_cnt = 2;
						default: need_cnt = 3;
					endcase
				end
			end

			foreach (units[k]) begin
				unit_item.code_unit = units[k];
				unit_item.run_last = (k == units.size() - 1);
				unit_item.string_last = (k == units.size() - 1) && it.string_end;
				expected_units.push_back(unit_item);
			end
		endfunction

		// Compares one accepted unit with the oldest expectation.
		function void check_unit(input utf16_item_t got);
			utf16_item_t want;

			if (expected_units.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected unit %h run_last %b string_last %b",
						got.code_unit, got.run_last, got.string_last);
				return;
			end
			want = expected_units.pop_front();
			if (got.code_unit !== want.code_unit || got.run_last !== want.run_last ||
					got.string_last !== want.string_last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unit mismatch: expected %h/%b/%b, got %h/%b/%b",
						want.code_unit, want.run_last, want.string_last,
						got.code_unit, got.run_last, got.string_last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	utf8_item_t utf8 = '0;
	logic empty;
	logic pop = 1'b0;
	utf16_item_t utf16;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	logic sender_idles = 1'b0;
	logic sink_stalls = 1'b0;
	int pop_hold = 0;
	int quiet_cycles = 0;
	int sent_in_phase = 0;
	utf16_scoreboard sb = new();

	utf8_to_utf16_transcoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.utf8(utf8),
		.empty(empty),
		.pop(pop),
		.utf16(utf16),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Gap lengths: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side: pop in bursts with random stalls in between when sink_stalls is set, else pop continuously.
	always @(posedge clk) begin : sink_drive
		int stall;
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold != 0) begin
			pop_hold <= pop_hold - 1;
		end else if (pop || !sink_stalls) begin
			stall = sink_stalls ? pick_gap() : 0;
			pop <= (stall == 0);
			pop_hold <= (stall == 0) ? $urandom_range(0, 7) : stall - 1;
		end else begin
			pop <= 1'b1;
			pop_hold <= $urandom_range(0, 7);
		end
	end

	// Accepted items on both sides go to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && push && !full)
			sb.note_byte(utf8);
		if (arst_n && pop && !empty)
			sb.check_unit(utf16);
	end

	// The run ends when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Offers one byte, after an optional gap, and returns at the edge that accepts it.
	task automatic send_byte(input logic [7:0] b, input logic e);
		int gap;
		gap = sender_idles ? pick_gap() : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		utf8 <= '{data_byte: b, string_end: e};
		do @(posedge clk); while (full);
		sent_in_phase++;
	endtask

	// One random string, mostly well-formed characters with random content.
	task automatic send_string();
		logic [7:0] bytes_q [$];
		int nchars;
		int kind;
		int conts;
		int keep;
		nchars = $urandom_range(1, 10);
		repeat (nchars) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				bytes_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
			end else if (kind >= 80 && kind < 85) begin
				bytes_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (kind >= 85 && kind < 90) begin
				bytes_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
			end else if (kind >= 95) begin
				bytes_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				// Multi-byte sequence; the 90..94 band cuts it short.
				if (kind >= 90)
					conts = $urandom_range(1, 3);
				else
					conts = (kind < 50) ? 1 : (kind < 65) ? 2 : 3;
				case (conts)
					1: bytes_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
					2: bytes_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
					default: bytes_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
				endcase
				keep = (kind >= 90) ? $urandom_range(0, conts - 1) : conts;
				repeat (keep) bytes_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end
		end
		foreach (bytes_q[k])
			send_byte(bytes_q[k], k == bytes_q.size() - 1);
	endtask

	// Stops the sender and waits until every expected unit has come out.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_repl(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_repl(v);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed strings with the reset replacement unit.
		sink_stalls <= 1'b1;
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h80, 1'b0); // stray continuations
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF8, 1'b0); // invalid leads
		send_byte(8'hFF, 1'b1);
		send_byte(8'hDF, 1'b0); // largest two-byte form
		send_byte(8'hBF, 1'b0);
		send_byte(8'hE2, 1'b0); // three-byte form
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hF7, 1'b0); // largest four-byte form, a surrogate pair
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
		send_byte(8'hC0, 1'b0); // plain byte inside a sequence
		send_byte(8'h41, 1'b0);
		send_byte(8'hF0, 1'b0); // three held bytes flushed by an invalid lead
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF8, 1'b1);
		send_byte(8'hE0, 1'b0); // sequence cut off at the end of the string
		send_byte(8'h80, 1'b1);
		send_byte(8'hC2, 1'b1); // lead byte as the final byte
		drain();

		// Random phases, each with its own replacement unit and an idling mix.
		for (int p = 0; p < 5; p++) begin
			sender_idles <= (p == 1 || p == 2 || p == 4);
			sink_stalls <= (p == 1 || p == 3 || p == 4);
			case (p)
				0: write_repl(16'h0000);
				1: write_repl(16'hFFFF);
				4: write_repl(16'hFFFD);
				default: write_repl(16'($urandom));
			endcase
			sent_in_phase = 0;
			while (sent_in_phase < PHASE_BYTES)
				send_string();
			drain();
		end

		sink_stalls <= 1'b0;
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
